// ===== src/ras_pkg.sv =====
package ras_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;
    localparam int DEFAULT_ADDR_BITS = 64;
    localparam int SETTING_W         = 7;
    localparam int ENTRY_COUNT_W     = 6;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

// ===== src/ras_cell.sv =====
module ras_cell #(
    parameter int ADDR_BITS = ras_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                  aclk,
    input  ras_pkg::shift_ctrl_t  ctrl,
    input  logic [ADDR_BITS-1:0]  newer_entry,
    input  logic [ADDR_BITS-1:0]  older_entry,
    output logic [ADDR_BITS-1:0]  entry
);

    logic [ADDR_BITS-1:0] entry_reg;
    logic [ADDR_BITS-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push) begin
            entry_next = newer_entry;
        end else if (ctrl.pop) begin
            entry_next = older_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/return_address_stack.sv =====
// Return address stack for trace decoding.
// The s_ channel carries one word per operation: s_func selects a push of
// s_return_address or a pop. The m_ channel returns one word per operation:
// the popped address (zero unless a non-empty pop in address mode), an empty
// flag for a pop on an empty stack, and the entry count after the operation.
// The cfg_ channel writes the signed stack setting: positive is the depth of
// the address stack (capped at MAX_DEPTH), negative keeps only a counter that
// saturates at its magnitude (also capped at MAX_DEPTH), zero turns the stack
// off. A write empties it. Entries live in a row of cells that shift toward
// the oldest end on a push and toward the newest end on a pop; a push into a
// full stack drops the oldest entry.
// m_valid rises in the cycle after acceptance. One word is accepted per cycle
// while s_ready is high; the cell shift and count update happen on acceptance.
// A result waits in the output register while m_ready is low; s_ready stays
// high as long as that register is empty or being emptied in the same cycle.
// Reset empties the stack, sets the setting to zero and drops any result.
module return_address_stack #(
    parameter int MAX_DEPTH = ras_pkg::DEFAULT_MAX_DEPTH,
    parameter int ADDR_BITS = ras_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ras_pkg::SETTING_W-1:0]         cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [ADDR_BITS-1:0]                  s_return_address,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ADDR_BITS-1:0]                  m_popped_address,
    output logic                                  m_was_empty,
    output logic [ras_pkg::ENTRY_COUNT_W-1:0]     m_entry_count
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int LIM_W = (CNT_W > ras_pkg::SETTING_W) ? CNT_W : ras_pkg::SETTING_W;
    localparam int EXT_W = (CNT_W > ras_pkg::ENTRY_COUNT_W) ? CNT_W : ras_pkg::ENTRY_COUNT_W;

    logic                 cfg_fire;
    logic                 s_fire;
    logic                 is_push;
    logic                 is_pop;
    logic                 count_zero;

    logic [ras_pkg::SETTING_W-1:0] setting_mag;
    logic [LIM_W-1:0]              mag_ext;
    logic [CNT_W-1:0]              limit_cfg;

    logic [CNT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]     limit_next;
    logic                 addr_mode_reg;
    logic                 addr_mode_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     count_op;
    logic [EXT_W-1:0]     count_ext;

    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [ADDR_BITS-1:0]              m_popped_address_reg;
    logic [ADDR_BITS-1:0]              m_popped_address_next;
    logic                              m_was_empty_reg;
    logic                              m_was_empty_next;
    logic [ras_pkg::ENTRY_COUNT_W-1:0] m_entry_count_reg;
    logic [ras_pkg::ENTRY_COUNT_W-1:0] m_entry_count_next;

    ras_pkg::shift_ctrl_t  shift_ctrl;
    logic [ADDR_BITS-1:0]  cell_entry [MAX_DEPTH];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign s_fire    = s_valid & s_ready;
    assign is_push   = s_fire & (s_func == ras_pkg::FUNC_PUSH);
    assign is_pop    = s_fire & (s_func == ras_pkg::FUNC_POP);
    assign count_zero = (count_reg == '0);

    // Magnitude of the signed setting, capped at the number of cells.
    assign setting_mag = cfg_data[ras_pkg::SETTING_W-1] ? (~cfg_data + 1'b1) : cfg_data;
    assign mag_ext     = LIM_W'(setting_mag);
    assign limit_cfg   = (mag_ext > LIM_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH)
                                                       : mag_ext[CNT_W-1:0];

    always_comb begin
        limit_next     = limit_reg;
        addr_mode_next = addr_mode_reg;
        if (cfg_fire) begin
            limit_next     = limit_cfg;
            addr_mode_next = ~cfg_data[ras_pkg::SETTING_W-1] && (cfg_data != '0);
        end
    end

    always_comb begin
        count_op = count_reg;
        if (is_push && (count_reg < limit_reg)) begin
            count_op = count_reg + 1'b1;
        end else if (is_pop && !count_zero) begin
            count_op = count_reg - 1'b1;
        end
        count_next = cfg_fire ? '0 : count_op;
    end

    assign shift_ctrl.push = is_push & addr_mode_reg;
    assign shift_ctrl.pop  = is_pop & addr_mode_reg & ~count_zero;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
            logic [ADDR_BITS-1:0] newer_entry;
            logic [ADDR_BITS-1:0] older_entry;
            if (gi == 0) begin : g_first
                assign newer_entry = s_return_address;
            end else begin : g_inner
                assign newer_entry = cell_entry[gi-1];
            end
            if (gi == MAX_DEPTH - 1) begin : g_last
                assign older_entry = '0;
            end else begin : g_mid
                assign older_entry = cell_entry[gi+1];
            end
            ras_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (shift_ctrl),
                .newer_entry (newer_entry),
                .older_entry (older_entry),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    assign count_ext = EXT_W'(count_op);

    always_comb begin
        m_valid_next          = m_valid_reg;
        m_popped_address_next = m_popped_address_reg;
        m_was_empty_next      = m_was_empty_reg;
        m_entry_count_next    = m_entry_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next          = 1'b1;
            m_popped_address_next = shift_ctrl.pop ? cell_entry[0] : '0;
            m_was_empty_next      = is_pop & count_zero;
            m_entry_count_next    = count_ext[ras_pkg::ENTRY_COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= '0;
            addr_mode_reg <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            limit_reg     <= limit_next;
            addr_mode_reg <= addr_mode_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_popped_address_reg <= m_popped_address_next;
        m_was_empty_reg      <= m_was_empty_next;
        m_entry_count_reg    <= m_entry_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_popped_address = m_popped_address_reg;
    assign m_was_empty      = m_was_empty_reg;
    assign m_entry_count    = m_entry_count_reg;

    a_count_in_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= limit_reg)
        else $error("Entry count exceeds the stack limit.");

    a_empty_pop_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        is_pop && count_zero |=> m_valid && m_was_empty && (m_popped_address == '0))
        else $error("Pop on an empty stack did not report empty.");

    a_counter_mode_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        is_pop && !addr_mode_reg |=> m_popped_address == '0)
        else $error("Pop outside address mode returned a nonzero address.");

    a_off_mode_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (limit_reg == '0) |-> count_zero)
        else $error("Stack holds entries while switched off.");

endmodule
